FILE: hdl/bounded_deque_engine_defines.svh
// assertion macros shared by the deque engine rtl
`ifndef BOUNDED_DEQUE_ENGINE_DEFINES_SVH
`define BOUNDED_DEQUE_ENGINE_DEFINES_SVH

// clocked property, held off while reset is asserted
`define BDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define BDE_ASSERT_NEVER(label, cond, msg) \
  `BDE_ASSERT(label, !(cond), msg)

`endif

FILE: hdl/bde_pkg.sv
// shared constants and types for the deque engine
`default_nettype none

package bde_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_WALK_FWD   = 3'd4,
    REQ_WALK_BWD   = 3'd5
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // one access to the element store
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } store_req_t;

endpackage

`default_nettype wire

FILE: hdl/bounded_deque_engine.sv
// Bounded double-ended queue of signed words held in a ring store.
// Request channel: req_type_i and item_value_i under in_valid_i / in_ready_o.
// Result channel: status_o, out_value_o and last_of_run_o under
// out_valid_o / out_ready_i; last_of_run_o marks the final result of a request.
// One request is in hand at a time; in_ready_o is high only when idle.
// A small sequencer drives one shared ring address unit and a store with one write
// port and one registered read port. Steps from acceptance to a valid result:
//   overflow or underflow: straight to the result
//   push: address, write
//   pop: address and read, capture
//   walk: address and read, capture for each element, each further element
//   started only once the previous result has been taken.
// Request codes 6 and 7 are dropped with no result.
// After reset the queue is empty; the store contents are not cleared and
// need no clearing pass since only written slots are ever read.
// A stalled receiver holds the result register and the sequencer waits.
`default_nettype none

`include "bounded_deque_engine_defines.svh"

module bounded_deque_engine (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic        [bde_pkg::REQ_W-1:0]   req_type_i,
  input  wire logic signed [bde_pkg::DATA_W-1:0]  item_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic             [bde_pkg::STAT_W-1:0]  status_o,
  output logic signed      [bde_pkg::DATA_W-1:0]  out_value_o,
  output logic                                    last_of_run_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_READ,
    S_OUT
  } state_e;

  localparam logic [bde_pkg::CNT_W-1:0] CapCnt  = bde_pkg::CNT_W'(bde_pkg::CAPACITY);
  localparam logic [bde_pkg::IDX_W-1:0] LastOff = bde_pkg::IDX_W'(bde_pkg::CAPACITY - 1);
  localparam logic [bde_pkg::IDX_W-1:0] OneOff  = bde_pkg::IDX_W'(1);

  state_e                        state_q;
  logic [bde_pkg::REQ_W-1:0]     req_q;
  logic [bde_pkg::DATA_W-1:0]    val_q;
  logic [bde_pkg::IDX_W-1:0]     front_q;
  logic [bde_pkg::CNT_W-1:0]     count_q;
  logic [bde_pkg::CNT_W-1:0]     k_q;
  bde_pkg::status_e              status_q;
  logic [bde_pkg::DATA_W-1:0]    out_value_q;
  logic                          last_q;

  logic [bde_pkg::CNT_W-1:0]     cnt_m1;
  logic [bde_pkg::CNT_W-1:0]     back_off;
  logic [bde_pkg::CNT_W-1:0]     k_p1;
  logic [bde_pkg::IDX_W-1:0]     offset;
  logic [bde_pkg::IDX_W-1:0]     slot;
  logic [bde_pkg::DATA_W-1:0]    rdata;
  bde_pkg::store_req_t           store_req;
  logic                          is_push;
  logic                          is_pop;
  logic                          full;
  logic                          empty;

  assign cnt_m1   = count_q - bde_pkg::CNT_W'(1);
  assign back_off = cnt_m1 - k_q;
  assign k_p1     = k_q + bde_pkg::CNT_W'(1);
  assign full     = (count_q == CapCnt);
  assign empty    = (count_q == '0);
  assign is_push  = (req_q == bde_pkg::REQ_PUSH_FRONT) || (req_q == bde_pkg::REQ_PUSH_BACK);
  assign is_pop   = (req_q == bde_pkg::REQ_POP_FRONT) || (req_q == bde_pkg::REQ_POP_BACK);

  // offset fed to the shared address unit
  always_comb begin
    offset = '0;
    if (state_q == S_CALC) begin
      case (req_q)
        bde_pkg::REQ_PUSH_FRONT: offset = LastOff;
        bde_pkg::REQ_PUSH_BACK:  offset = count_q[bde_pkg::IDX_W-1:0];
        bde_pkg::REQ_POP_FRONT:  offset = '0;
        bde_pkg::REQ_POP_BACK:   offset = cnt_m1[bde_pkg::IDX_W-1:0];
        bde_pkg::REQ_WALK_FWD:   offset = k_q[bde_pkg::IDX_W-1:0];
        bde_pkg::REQ_WALK_BWD:   offset = back_off[bde_pkg::IDX_W-1:0];
        default:                 offset = '0;
      endcase
    end else if (state_q == S_READ) begin
      // new front after a front pop
      offset = OneOff;
    end
  end

  bde_slot_unit u_slot (
    .base_i   (front_q),
    .offset_i (offset),
    .slot_o   (slot)
  );

  always_comb begin
    store_req.we    = (state_q == S_CALC) && is_push;
    store_req.waddr = slot;
    store_req.wdata = val_q;
    store_req.re    = (state_q == S_CALC) && !is_push;
    store_req.raddr = slot;
  end

  bde_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      front_q     <= '0;
      count_q     <= '0;
      k_q         <= '0;
      status_q    <= bde_pkg::ST_OK;
      last_q      <= 1'b0;
      val_q       <= '0;
      out_value_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q       <= req_type_i;
            val_q       <= item_value_i;
            k_q         <= '0;
            out_value_q <= '0;
            last_q      <= 1'b1;
            case (req_type_i)
              bde_pkg::REQ_PUSH_FRONT, bde_pkg::REQ_PUSH_BACK: begin
                if (full) begin
                  status_q <= bde_pkg::ST_OVERFLOW;
                  state_q  <= S_OUT;
                end else begin
                  status_q <= bde_pkg::ST_OK;
                  state_q  <= S_CALC;
                end
              end
              bde_pkg::REQ_POP_FRONT, bde_pkg::REQ_POP_BACK,
              bde_pkg::REQ_WALK_FWD, bde_pkg::REQ_WALK_BWD: begin
                if (empty) begin
                  status_q <= bde_pkg::ST_UNDERFLOW;
                  state_q  <= S_OUT;
                end else begin
                  status_q <= bde_pkg::ST_OK;
                  state_q  <= S_CALC;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_CALC: begin
          if (is_push) begin
            if (req_q == bde_pkg::REQ_PUSH_FRONT) begin
              front_q <= slot;
            end
            count_q <= count_q + bde_pkg::CNT_W'(1);
            state_q <= S_OUT;
          end else begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          out_value_q <= rdata;
          if (is_pop) begin
            if (req_q == bde_pkg::REQ_POP_FRONT) begin
              front_q <= slot;
            end
            count_q <= cnt_m1;
            last_q  <= 1'b1;
          end else begin
            last_q  <= (k_p1 == count_q);
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_p1;
              state_q <= S_CALC;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign status_o      = status_q;
  assign out_value_o   = out_value_q;
  assign last_of_run_o = last_q;

  `BDE_ASSERT_NEVER(a_count_bound, count_q > CapCnt, "element count above capacity")
  `BDE_ASSERT_NEVER(a_one_in_hand, in_ready_o && out_valid_o, "accepting while a result waits")
  `BDE_ASSERT(a_err_zero, (out_valid_o && (status_o != bde_pkg::ST_OK)) |-> (out_value_o == '0), "error result carries a value")
  `BDE_ASSERT(a_push_count, (state_q == S_CALC && is_push) |=> (count_q == $past(count_q) + bde_pkg::CNT_W'(1)), "push did not grow the queue")
  `BDE_ASSERT(a_walk_in_range, (state_q == S_CALC && !is_push && !is_pop) |-> (k_q < count_q), "walk index past the live run")

endmodule

`default_nettype wire

FILE: hdl/bde_store.sv
// ring store of elements, one write and one registered read per cycle
`default_nettype none

module bde_store (
  input  wire logic                      clk_i,
  input  wire bde_pkg::store_req_t       req_i,
  output logic [bde_pkg::DATA_W-1:0]     rdata_o
);

  logic [bde_pkg::DATA_W-1:0] mem_q [bde_pkg::CAPACITY];
  logic [bde_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/bde_slot_unit.sv
// shared ring address unit: (base + offset) mod capacity
`default_nettype none

module bde_slot_unit (
  input  wire logic [bde_pkg::IDX_W-1:0] base_i,
  input  wire logic [bde_pkg::IDX_W-1:0] offset_i,
  output logic      [bde_pkg::IDX_W-1:0] slot_o
);

  localparam logic [bde_pkg::IDX_W:0] CapExt = (bde_pkg::IDX_W + 1)'(bde_pkg::CAPACITY);

  logic [bde_pkg::IDX_W:0] sum;
  logic [bde_pkg::IDX_W:0] wrapped;

  // both operands stay below capacity, so one subtract is enough
  assign sum     = {1'b0, base_i} + {1'b0, offset_i};
  assign wrapped = sum - CapExt;
  assign slot_o  = (sum >= CapExt) ? wrapped[bde_pkg::IDX_W-1:0] : sum[bde_pkg::IDX_W-1:0];

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench for the bounded deque engine
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bde_pkg::*;

  // request codes the block drops without a result
  localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

  localparam int RANDOM_ITEMS  = 380;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 600000;

  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } reply_t;

  typedef struct {
    logic [REQ_W-1:0]         req;
    logic signed [DATA_W-1:0] value;
    bit                       has_fixed;
    logic [STAT_W-1:0]        fixed_status;
    logic signed [DATA_W-1:0] fixed_value;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [REQ_W-1:0]         req_type_i = '0;
  logic signed [DATA_W-1:0] item_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] out_value_o;
  logic                     last_of_run_o;

  // typed-in expectation travelling with the request on the wire
  bit                       fixed_en = 1'b0;
  logic [STAT_W-1:0]        fixed_status = '0;
  logic signed [DATA_W-1:0] fixed_value = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // mirror of the deque contents
  logic signed [DATA_W-1:0] ring_copy [CAPACITY];
  int head_slot  = 0;
  int live_count = 0;

  reply_t replies_due [$];

  int requests_sent   = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int overflows       = 0;
  int underflows      = 0;
  int walks           = 0;
  int peak_fill       = 0;
  int cycle_count     = 0;

  stim_row_t directed_rows [23] = '{
    '{REQ_POP_FRONT,  32'h1234_5678, 1'b1, ST_UNDERFLOW, 32'h0},
    '{REQ_POP_BACK,   32'h0,         1'b1, ST_UNDERFLOW, 32'h0},
    '{REQ_WALK_FWD,   32'h0,         1'b1, ST_UNDERFLOW, 32'h0},
    '{REQ_WALK_BWD,   32'hffff_ffff, 1'b1, ST_UNDERFLOW, 32'h0},
    '{REQ_PUSH_FRONT, WORD_MAX,      1'b1, ST_OK,        32'h0},
    '{REQ_POP_BACK,   32'h0,         1'b1, ST_OK,        WORD_MAX},
    '{REQ_PUSH_BACK,  WORD_MIN,      1'b1, ST_OK,        32'h0},
    '{REQ_POP_FRONT,  32'h0,         1'b1, ST_OK,        WORD_MIN},
    '{REQ_POP_FRONT,  32'h0,         1'b1, ST_UNDERFLOW, 32'h0},
    '{REQ_RSVD_A,     32'hffff_ffff, 1'b0, ST_OK,        32'h0},
    '{REQ_RSVD_B,     32'h0,         1'b0, ST_OK,        32'h0},
    '{REQ_PUSH_BACK,  32'hffff_ffff, 1'b1, ST_OK,        32'h0},
    '{REQ_PUSH_FRONT, 32'h0,         1'b1, ST_OK,        32'h0},
    '{REQ_PUSH_BACK,  32'h5555_5555, 1'b1, ST_OK,        32'h0},
    '{REQ_PUSH_FRONT, 32'haaaa_aaaa, 1'b1, ST_OK,        32'h0},
    '{REQ_WALK_FWD,   32'h0,         1'b0, ST_OK,        32'h0},
    '{REQ_WALK_BWD,   32'h0,         1'b0, ST_OK,        32'h0},
    '{REQ_POP_BACK,   32'h0,         1'b0, ST_OK,        32'h0},
    '{REQ_POP_FRONT,  32'h0,         1'b0, ST_OK,        32'h0},
    '{REQ_WALK_FWD,   32'h0,         1'b0, ST_OK,        32'h0},
    '{REQ_POP_BACK,   32'h0,         1'b0, ST_OK,        32'h0},
    '{REQ_POP_FRONT,  32'h0,         1'b0, ST_OK,        32'h0},
    '{REQ_WALK_BWD,   32'h0,         1'b1, ST_UNDERFLOW, 32'h0}
  };

  bounded_deque_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_value_o   (out_value_o),
    .last_of_run_o (last_of_run_o)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void add_reply(logic [STAT_W-1:0] status, logic signed [DATA_W-1:0] value,
                                    logic last);
    reply_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    replies_due.push_back(r);
  endfunction

  // applies one request to the mirror and queues the replies it causes
  function automatic void deque_apply(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] val);
    int slot;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (live_count >= CAPACITY) begin
          add_reply(ST_OVERFLOW, '0, 1'b1);
          overflows++;
        end else begin
          if (req == REQ_PUSH_FRONT) begin
            head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
            ring_copy[head_slot] = val;
          end else begin
            ring_copy[(head_slot + live_count) % CAPACITY] = val;
          end
          live_count++;
          if (live_count > peak_fill) peak_fill = live_count;
          add_reply(ST_OK, '0, 1'b1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (live_count == 0) begin
          add_reply(ST_UNDERFLOW, '0, 1'b1);
          underflows++;
        end else begin
          if (req == REQ_POP_FRONT) begin
            add_reply(ST_OK, ring_copy[head_slot], 1'b1);
            head_slot = (head_slot + 1) % CAPACITY;
          end else begin
            add_reply(ST_OK, ring_copy[(head_slot + live_count - 1) % CAPACITY], 1'b1);
          end
          live_count--;
        end
      end
      REQ_WALK_FWD, REQ_WALK_BWD: begin
        walks++;
        if (live_count == 0) begin
          add_reply(ST_UNDERFLOW, '0, 1'b1);
          underflows++;
        end else begin
          for (int k = 0; k < live_count; k++) begin
            slot = (req == REQ_WALK_FWD) ? k : live_count - 1 - k;
            add_reply(ST_OK, ring_copy[(head_slot + slot) % CAPACITY], k == live_count - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // transaction monitor: results are checked before a new request is mirrored
  always @(posedge clk_i) begin
    reply_t want;
    int     held;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d value %0d last %0b",
                   $time, status_o, out_value_o, last_of_run_o);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          results_checked++;
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
            mismatches++;
          end
          if (out_value_o !== want.value) begin
            $display("%0t: value expected %0d, got %0d", $time, want.value, out_value_o);
            mismatches++;
          end
          if (last_of_run_o !== want.last) begin
            $display("%0t: last flag expected %0b, got %0b", $time, want.last, last_of_run_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (req_type_i <= REQ_WALK_BWD) requests_sent++;
        held = replies_due.size();
        deque_apply(req_type_i, item_value_i);
        if (fixed_en) begin
          while (replies_due.size() > held) void'(replies_due.pop_back());
          add_reply(fixed_status, fixed_value, 1'b1);
        end
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] val,
                              bit has_fixed, logic [STAT_W-1:0] fstat,
                              logic signed [DATA_W-1:0] fval);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    item_value_i <= val;
    fixed_en     <= has_fixed;
    fixed_status <= fstat;
    fixed_value  <= fval;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_plain(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] val);
    send_request(req, val, 1'b0, ST_OK, '0);
  endtask

  function automatic logic [REQ_W-1:0] either_end(logic [REQ_W-1:0] front_code,
                                                 logic [REQ_W-1:0] back_code);
    return $urandom_range(1) ? front_code : back_code;
  endfunction

  // sender holds off until every outstanding result has been taken
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int target;
    int pick;
    int burst;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].value, directed_rows[i].has_fixed,
                   directed_rows[i].fixed_status, directed_rows[i].fixed_value);
    end
    wait_for_drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      target = requests_sent + RANDOM_ITEMS / 4;

      // odd phases: fill to capacity, overflow at both ends, walk both ways, then empty it and underflow once
      if (ph % 2 == 1) begin
        while (live_count < CAPACITY)
          send_plain(either_end(REQ_PUSH_FRONT, REQ_PUSH_BACK), random_word());
        send_plain(REQ_PUSH_FRONT, random_word());
        send_plain(REQ_PUSH_BACK, random_word());
        send_plain(REQ_WALK_FWD, random_word());
        send_plain(REQ_WALK_BWD, random_word());
        while (live_count > 0)
          send_plain(either_end(REQ_POP_FRONT, REQ_POP_BACK), random_word());
        send_plain(either_end(REQ_POP_FRONT, REQ_POP_BACK), random_word());
      end

      while (requests_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          pick = $urandom_range(99);
          if (pick < ((live_count < CAPACITY / 2) ? 60 : 35))
            send_plain(either_end(REQ_PUSH_FRONT, REQ_PUSH_BACK), random_word());
          else if (pick < 88)
            send_plain(either_end(REQ_POP_FRONT, REQ_POP_BACK), random_word());
          else
            send_plain(either_end(REQ_WALK_FWD, REQ_WALK_BWD), random_word());
        end else if (pick < 65) begin
          burst = $urandom_range(1, 10);
          repeat (burst)
            send_plain(either_end(REQ_PUSH_FRONT, REQ_PUSH_BACK), random_word());
        end else if (pick < 85) begin
          burst = $urandom_range(1, 10);
          repeat (burst)
            send_plain(either_end(REQ_POP_FRONT, REQ_POP_BACK), random_word());
        end else if (pick < 95) begin
          send_plain(either_end(REQ_WALK_FWD, REQ_WALK_BWD), random_word());
        end else begin
          send_plain(either_end(REQ_RSVD_A, REQ_RSVD_B), random_word());
        end
      end
      wait_for_drain();
    end

    $display("tb: %0d requests over four idling phases, %0d walks, %0d overflows, %0d underflows",
             requests_sent, walks, overflows, underflows);
    $display("tb: %0d results checked, peak fill %0d of %0d, %0d mismatches",
             results_checked, peak_fill, CAPACITY, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/bde_pkg.sv
hdl/bde_store.sv
hdl/bde_slot_unit.sv
hdl/bounded_deque_engine.sv
sim/testbench.sv
